FILE: rtl/core/gn2d_pkg.sv
// Shared types, constants and the permutation table of the 2-D gradient noise unit.
package gn2d_pkg;

    localparam int COORD_W           = 32;
    localparam int NOISE_W           = 17;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int PIPE_STAGES       = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [NOISE_W-1:0]        noise_t;
    typedef logic [1:0]                grad_sel_t;

    // Gradient choice from the low two bits of a corner hash
    localparam grad_sel_t GRAD_POS_X = 2'd0;
    localparam grad_sel_t GRAD_NEG_X = 2'd1;
    localparam grad_sel_t GRAD_POS_Y = 2'd2;
    localparam grad_sel_t GRAD_NEG_Y = 2'd3;

    // Reference permutation of 256 entries; every lookup wraps its index to
    // 8 bits and reads this single list.
    localparam logic [7:0] PERM_BASE [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM_BASE[idx];
    endfunction

endpackage

FILE: rtl/core/gn2d_coord_if.sv
// Coordinate channel: valid/ready handshake carrying one x/y sample position.
interface gn2d_coord_if;
    logic                 valid;
    logic                 ready;
    gn2d_pkg::coord_t     x_coord;
    gn2d_pkg::coord_t     y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: rtl/core/gn2d_noise_if.sv
// Noise channel: valid/ready handshake carrying one noise result.
interface gn2d_noise_if;
    logic                 valid;
    logic                 ready;
    gn2d_pkg::noise_t     noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

FILE: rtl/core/gradient_noise_2d_unit.sv
// Top level of the pipelined 2-D gradient noise unit.
//
// Usage: present an x/y coordinate pair (signed, FRAC_BITS fraction bits) on
// the coord channel; one word per cycle is taken when valid and ready are high.
// Each accepted word yields exactly one noise word, unsigned Q1.16 in 0..65536,
// on the noise channel, in order.
// Throughput: one word per cycle while the output is not stalled, set by the
// six-stage register pipeline (absolute value, permutation reads, corner
// hashes, corner gradients, two lerp stages) with fade multipliers alongside.
// Each stage holds its own valid bit and moves on whenever the stage after it
// is empty or moving, so bubbles fill in while the output is stalled.
// When the receiver holds ready low the result word stays on the port and the
// stages behind it fill up; coord.ready falls only once every stage is full.
// Reset clears all valid bits; the permutation ROM is constant logic and needs
// no load.
module gradient_noise_2d_unit #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    gn2d_coord_if.sink    coord,
    gn2d_noise_if.source  noise
);
    import gn2d_pkg::*;

    localparam int VW = FRAC_BITS + 4;
    localparam int MW = 2 * FRAC_BITS + 6;
    localparam int CW = FRAC_BITS + 2;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
    localparam logic signed [VW-1:0] TWO_V = VW'(2) << FRAC_BITS;

    logic [PIPE_STAGES-1:0]        valid_reg;
    logic [PIPE_STAGES-1:0]        en;

    // Stage 0: magnitudes split into cell index and fraction
    logic [COORD_W-1:0]            ax;
    logic [COORD_W-1:0]            ay;
    logic [7:0]                    xi0_reg, yi0_reg;
    logic [FRAC_BITS-1:0]          fx0_reg, fy0_reg;

    // Stage 1: first permutation reads
    logic [7:0]                    pa1_reg, pb1_reg, yi1_reg;
    logic [FRAC_BITS-1:0]          fx1_reg, fy1_reg;

    // Stage 2: corner hashes (gradient select bits only)
    logic [7:0]                    haa_hash, hab_hash, hba_hash, hbb_hash;
    grad_sel_t                     haa2_reg, hab2_reg, hba2_reg, hbb2_reg;
    logic [FRAC_BITS-1:0]          fx2_reg, fy2_reg;

    // Stage 3: corner gradient values
    logic signed [VW-1:0]          dx0, dx1, dy0, dy1;
    logic signed [VW-1:0]          gaa3_reg, gab3_reg, gba3_reg, gbb3_reg;
    logic [FRAC_BITS:0]            sx, sy;

    // Stage 4: lerp along x
    logic signed [VW-1:0]          d0, d1;
    logic signed [MW-1:0]          m0, m1;
    logic signed [VW-1:0]          r04_reg, r14_reg;
    logic [FRAC_BITS:0]            sy4_reg;

    // Stage 5: lerp along y, offset, clamp and scale
    logic signed [VW-1:0]          d2;
    logic signed [MW-1:0]          m2;
    logic signed [VW-1:0]          vsum;
    logic [CW-1:0]                 vclamp;
    logic [CW+15:0]                vscaled;
    logic [NOISE_W-1:0]            noise_next;
    logic [NOISE_W-1:0]            noise_reg;

    function automatic logic [COORD_W-1:0] mag(input coord_t raw);
        logic [COORD_W-1:0] neg;
        neg = ~raw + COORD_W'(1);
        if (raw == {1'b1, {(COORD_W-1){1'b0}}})
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (raw[COORD_W-1])
            return neg;
        else
            return raw;
    endfunction

    function automatic logic signed [VW-1:0] grad(
        input grad_sel_t            h,
        input logic signed [VW-1:0] gx,
        input logic signed [VW-1:0] gy
    );
        logic signed [VW-1:0] g;
        case (h)
            GRAD_POS_X: g = gx;
            GRAD_NEG_X: g = -gx;
            GRAD_POS_Y: g = gy;
            default:    g = -gy;
        endcase
        return g;
    endfunction

    // A stage advances when empty or when the stage after it advances
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || noise.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign coord.ready = en[0];
    assign noise.valid = valid_reg[PIPE_STAGES-1];
    assign noise.noise_value = noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= coord.valid;
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign ax = mag(coord.x_coord);
    assign ay = mag(coord.y_coord);

    gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .clk (clk),
        .en  (en[3:1]),
        .t   (fx0_reg),
        .s   (sx)
    );

    gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .clk (clk),
        .en  (en[3:1]),
        .t   (fy0_reg),
        .s   (sy)
    );

    assign haa_hash = perm_lookup(8'(pa1_reg + yi1_reg));
    assign hab_hash = perm_lookup(8'(pa1_reg + yi1_reg + 8'd1));
    assign hba_hash = perm_lookup(8'(pb1_reg + yi1_reg));
    assign hbb_hash = perm_lookup(8'(pb1_reg + yi1_reg + 8'd1));

    assign dx0 = $signed({4'b0, fx2_reg});
    assign dy0 = $signed({4'b0, fy2_reg});
    assign dx1 = dx0 - ONE_V;
    assign dy1 = dy0 - ONE_V;

    assign d0 = gba3_reg - gaa3_reg;
    assign d1 = gbb3_reg - gab3_reg;
    assign m0 = MW'($signed({1'b0, sx})) * MW'(d0);
    assign m1 = MW'($signed({1'b0, sx})) * MW'(d1);

    assign d2   = r14_reg - r04_reg;
    assign m2   = MW'($signed({1'b0, sy4_reg})) * MW'(d2);
    assign vsum = r04_reg + m2[FRAC_BITS+VW-1:FRAC_BITS] + ONE_V;

    always_comb
    begin
        if (vsum < 0)
            vclamp = '0;
        else if (vsum > TWO_V)
            vclamp = TWO_V[CW-1:0];
        else
            vclamp = vsum[CW-1:0];
        vscaled = {vclamp, 16'b0} >> (FRAC_BITS + 1);
        noise_next = vscaled[NOISE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xi0_reg <= ax[FRAC_BITS+7:FRAC_BITS];
            yi0_reg <= ay[FRAC_BITS+7:FRAC_BITS];
            fx0_reg <= ax[FRAC_BITS-1:0];
            fy0_reg <= ay[FRAC_BITS-1:0];
        end
        if (en[1])
        begin
            pa1_reg <= perm_lookup(xi0_reg);
            pb1_reg <= perm_lookup(8'(xi0_reg + 8'd1));
            yi1_reg <= yi0_reg;
            fx1_reg <= fx0_reg;
            fy1_reg <= fy0_reg;
        end
        if (en[2])
        begin
            haa2_reg <= haa_hash[1:0];
            hab2_reg <= hab_hash[1:0];
            hba2_reg <= hba_hash[1:0];
            hbb2_reg <= hbb_hash[1:0];
            fx2_reg  <= fx1_reg;
            fy2_reg  <= fy1_reg;
        end
        if (en[3])
        begin
            gaa3_reg <= grad(haa2_reg, dx0, dy0);
            gba3_reg <= grad(hba2_reg, dx1, dy0);
            gab3_reg <= grad(hab2_reg, dx0, dy1);
            gbb3_reg <= grad(hbb2_reg, dx1, dy1);
        end
        if (en[4])
        begin
            r04_reg <= gaa3_reg + m0[FRAC_BITS+VW-1:FRAC_BITS];
            r14_reg <= gab3_reg + m1[FRAC_BITS+VW-1:FRAC_BITS];
            sy4_reg <= sy;
        end
        if (en[5])
        begin
            noise_reg <= noise_next;
        end
    end

endmodule

FILE: rtl/core/gn2d_fade.sv
// Three-stage pipelined ease curve 6t^5-15t^4+10t^3 in fixed point.
module gn2d_fade #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  logic [FRAC_BITS-1:0] t,
    output logic [FRAC_BITS:0]   s
);
    import gn2d_pkg::*;

    localparam int LW = FRAC_BITS + 5;
    localparam int PW = 2 * FRAC_BITS + 6;
    localparam logic signed [LW-1:0] FIFTEEN_ONE = LW'(15) << FRAC_BITS;
    localparam logic signed [LW-1:0] TEN_ONE     = LW'(10) << FRAC_BITS;

    logic signed [LW-1:0]          t_lin;
    logic signed [LW-1:0]          lin;
    logic signed [PW-1:0]          prod_q;
    logic signed [LW-1:0]          q_next;
    logic [2*FRAC_BITS-1:0]        sq;
    logic [2*FRAC_BITS-1:0]        cube;
    logic [2*FRAC_BITS+3:0]        prod_s;

    logic signed [LW-1:0]          q1_reg;
    logic signed [LW-1:0]          q2_reg;
    logic [FRAC_BITS-1:0]          t1_reg;
    logic [FRAC_BITS-1:0]          t2_reg;
    logic [FRAC_BITS-1:0]          t3_reg;
    logic [FRAC_BITS:0]            s_reg;

    // q = floor(t*(6t-15)) + 10; the shift of a signed product floors
    assign t_lin  = $signed({5'b0, t});
    assign lin    = (t_lin <<< 2) + (t_lin <<< 1) - FIFTEEN_ONE;
    assign prod_q = PW'($signed({1'b0, t})) * PW'(lin);
    assign q_next = prod_q[FRAC_BITS+LW-1:FRAC_BITS] + TEN_ONE;
    assign sq     = (2*FRAC_BITS)'(t) * (2*FRAC_BITS)'(t);
    assign cube   = (2*FRAC_BITS)'(t2_reg) * (2*FRAC_BITS)'(t1_reg);
    // q stays in 1..10 units, so its low FRAC_BITS+4 bits hold it unsigned
    assign prod_s = (2*FRAC_BITS+4)'(t3_reg) * (2*FRAC_BITS+4)'(q2_reg[FRAC_BITS+3:0]);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q1_reg <= q_next;
            t1_reg <= t;
            t2_reg <= sq[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (en[1])
        begin
            q2_reg <= q1_reg;
            t3_reg <= cube[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (en[2])
        begin
            s_reg <= prod_s[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign s = s_reg;

endmodule
